// ===== sv/efc_pkg.sv =====
// ----------------------------------------------------------------------------
// efc_pkg: shared types and constants of the Ethernet frame classifier
// Holds the frame class codes, the protocol constants and the structs that
// pass the captured header and the decoded summary between the modules.
// ----------------------------------------------------------------------------
package efc_pkg;

  // Header bytes kept at fixed offsets (0 to 41) and bytes kept relative to
  // the start of the IPv4 payload (offsets 0 to 13 from there).
  localparam int unsigned FIX_BYTES = 42;
  localparam int unsigned L4_BYTES  = 14;

  localparam logic [15:0] ETH_HDR_BYTES  = 16'd14;
  localparam logic [15:0] MAX_LEN_FIELD  = 16'd1500;
  localparam logic [15:0] ETYPE_IPV4     = 16'h0800;
  localparam logic [15:0] ETYPE_ARP      = 16'h0806;
  localparam logic [15:0] ETYPE_RARP     = 16'h8035;
  localparam logic [15:0] ETYPE_IPV6     = 16'h86dd;
  localparam logic [7:0]  SAP_NETBEUI    = 8'hf0;
  localparam logic [7:0]  SAP_SNAP       = 8'haa;
  localparam logic [3:0]  IHL_MASK       = 4'hf;
  localparam logic [7:0]  TCP_FLAG_MASK  = 8'h3f;
  localparam logic [5:0]  IPV4_MIN_HDR   = 6'd20;
  localparam logic [7:0]  IP_PROTO_ICMP  = 8'd1;
  localparam logic [7:0]  IP_PROTO_TCP   = 8'd6;
  localparam logic [7:0]  IP_PROTO_UDP   = 8'd17;
  localparam logic [15:0] UDP_HDR_BYTES  = 16'd8;

  typedef enum logic [3:0] {
    CLS_RUNT       = 4'd0,
    CLS_NETBEUI    = 4'd1,
    CLS_SNAP       = 4'd2,
    CLS_LLC        = 4'd3,
    CLS_IPV4_BAD   = 4'd4,
    CLS_ICMP       = 4'd5,
    CLS_TCP        = 4'd6,
    CLS_UDP        = 4'd7,
    CLS_IPV4_OTHER = 4'd8,
    CLS_ARP        = 4'd9,
    CLS_RARP       = 4'd10,
    CLS_IPV6       = 4'd11,
    CLS_OTHER      = 4'd12
  } cls_t;

  typedef enum logic [4:0] {
    SVC_NONE     = 5'd0,
    SVC_HIGH_A   = 5'd1,
    SVC_HIGH_B   = 5'd2,
    SVC_DHCP     = 5'd3,
    SVC_DNS      = 5'd4,
    SVC_NTP      = 5'd5,
    SVC_NB_NS    = 5'd6,
    SVC_NB_DGM   = 5'd7,
    SVC_NB_SSN   = 5'd8,
    SVC_FTP_DATA = 5'd9,
    SVC_FTP      = 5'd10,
    SVC_SSH      = 5'd11,
    SVC_TELNET   = 5'd12,
    SVC_SMTP     = 5'd13,
    SVC_HTTP     = 5'd14,
    SVC_POP3     = 5'd15,
    SVC_IMAP     = 5'd16,
    SVC_HTTPS    = 5'd17
  } svc_t;

  typedef struct packed {
    logic [L4_BYTES-1:0][7:0]  l4;
    logic [FIX_BYTES-1:0][7:0] fix;
  } hdr_t;

  typedef struct packed {
    cls_t        frame_class;
    logic [15:0] frame_length;
    logic [15:0] type_field;
    logic [47:0] source_address;
    logic [47:0] dest_address;
    logic [15:0] source_port;
    logic [15:0] dest_port;
    svc_t        source_service;
    svc_t        dest_service;
    logic [15:0] code_a;
    logic [7:0]  code_b;
    logic [47:0] value_a;
  } res_t;

  function automatic svc_t port_service(input logic [15:0] port);
    svc_t svc;
    unique case (port)
      16'd32770, 16'd32771: svc = SVC_HIGH_A;
      16'd49171:            svc = SVC_HIGH_B;
      16'd67, 16'd68:       svc = SVC_DHCP;
      16'd53:               svc = SVC_DNS;
      16'd123:              svc = SVC_NTP;
      16'd137:              svc = SVC_NB_NS;
      16'd138:              svc = SVC_NB_DGM;
      16'd139:              svc = SVC_NB_SSN;
      16'd20:               svc = SVC_FTP_DATA;
      16'd21:               svc = SVC_FTP;
      16'd22:               svc = SVC_SSH;
      16'd23:               svc = SVC_TELNET;
      16'd25:               svc = SVC_SMTP;
      16'd80:               svc = SVC_HTTP;
      16'd110:              svc = SVC_POP3;
      16'd143:              svc = SVC_IMAP;
      16'd443:              svc = SVC_HTTPS;
      default:              svc = SVC_NONE;
    endcase
    return svc;
  endfunction

endpackage

// ===== sv/efc_capture.sv =====
// ----------------------------------------------------------------------------
// efc_capture: byte counter and header field capture
// Counts the bytes of a frame and stores each byte that a later decode needs
// into a register of its own as it passes, fixed offsets and IPv4 payload
// offsets alike.
// ----------------------------------------------------------------------------
module efc_capture (
  input  logic            clk,
  input  logic            rst,
  input  logic            accept,
  input  logic [7:0]      data_byte,
  input  logic            last_byte,
  output efc_pkg::hdr_t   hdr,
  output logic [15:0]     frame_len
);

  logic [15:0]   byte_count;
  logic [15:0]   count_inc;
  logic [6:0]    l4_base;
  logic [15:0]   l4_off;
  efc_pkg::hdr_t hdr_q;
  logic [15:0]   len_q;

  assign count_inc = (byte_count == 16'hffff) ? byte_count : byte_count + 16'd1;

  // Start of the IPv4 payload. Byte 14 may still hold an older frame's value
  // while the count is low; slots written then are rewritten at their proper
  // offsets or fail the length check at decode.
  assign l4_base = 7'd14 + {1'b0, hdr_q.fix[14][3:0] & efc_pkg::IHL_MASK, 2'b00};
  assign l4_off  = byte_count - {9'd0, l4_base};

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count <= 16'd0;
    end else if (accept) begin
      byte_count <= last_byte ? 16'd0 : count_inc;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      for (int i = 0; i < efc_pkg::FIX_BYTES; i++) begin
        if (byte_count == 16'(i)) begin
          hdr_q.fix[i] <= data_byte;
        end
      end
      for (int k = 0; k < efc_pkg::L4_BYTES; k++) begin
        if (l4_off == 16'(k)) begin
          hdr_q.l4[k] <= data_byte;
        end
      end
      if (last_byte) begin
        len_q <= count_inc;
      end
    end
  end

  assign hdr       = hdr_q;
  assign frame_len = len_q;

endmodule

// ===== sv/efc_decode.sv =====
// ----------------------------------------------------------------------------
// efc_decode: frame summary decode
// Turns the captured header bytes and the final length into the class and
// the summary fields. A field counts only when all its bytes lie inside the
// frame.
// ----------------------------------------------------------------------------
module efc_decode (
  input  efc_pkg::hdr_t hdr,
  input  logic [15:0]   frame_len,
  output efc_pkg::res_t res
);

  always_comb begin
    logic [15:0] typ;
    logic [7:0]  dsap;
    logic [7:0]  ssap;
    logic [5:0]  ihl;
    logic [7:0]  proto;
    logic [15:0] l4w;
    logic [15:0] ulen;
    logic [15:0] sp;
    logic [15:0] dp;
    efc_pkg::svc_t ss;
    efc_pkg::svc_t ds;

    res              = '0;
    res.frame_class  = efc_pkg::CLS_RUNT;
    res.frame_length = frame_len;
    typ  = {hdr.fix[12], hdr.fix[13]};
    dsap = (frame_len >= 16'd15) ? hdr.fix[14] : 8'd0;
    ssap = (frame_len >= 16'd16) ? hdr.fix[15] : 8'd0;
    ihl  = {dsap[3:0] & efc_pkg::IHL_MASK, 2'b00};
    proto = (frame_len >= 16'd24) ? hdr.fix[23] : 8'd0;
    l4w  = efc_pkg::ETH_HDR_BYTES + {10'd0, ihl};
    sp   = (frame_len >= l4w + 16'd2) ? {hdr.l4[0], hdr.l4[1]} : 16'd0;
    dp   = (frame_len >= l4w + 16'd4) ? {hdr.l4[2], hdr.l4[3]} : 16'd0;
    ss   = efc_pkg::port_service(sp);
    ds   = efc_pkg::port_service(dp);
    ulen = (frame_len >= l4w + 16'd6) ? {hdr.l4[4], hdr.l4[5]} : 16'd0;

    if (frame_len >= efc_pkg::ETH_HDR_BYTES) begin
      res.type_field     = typ;
      res.dest_address   = {hdr.fix[0], hdr.fix[1], hdr.fix[2],
                            hdr.fix[3], hdr.fix[4], hdr.fix[5]};
      res.source_address = {hdr.fix[6], hdr.fix[7], hdr.fix[8],
                            hdr.fix[9], hdr.fix[10], hdr.fix[11]};
      if (typ <= efc_pkg::MAX_LEN_FIELD) begin
        res.code_a = {8'd0, dsap};
        res.code_b = ssap;
        if (dsap == efc_pkg::SAP_NETBEUI && ssap == efc_pkg::SAP_NETBEUI) begin
          res.frame_class = efc_pkg::CLS_NETBEUI;
          res.value_a     = {32'd0, typ};
        end else if (dsap == efc_pkg::SAP_SNAP && ssap == efc_pkg::SAP_SNAP) begin
          res.frame_class = efc_pkg::CLS_SNAP;
          res.value_a     = (frame_len >= 16'd22) ?
                            {32'd0, hdr.fix[20], hdr.fix[21]} : 48'd0;
        end else begin
          res.frame_class = efc_pkg::CLS_LLC;
          res.value_a     = {32'd0, typ};
        end
      end else if (typ == efc_pkg::ETYPE_IPV4) begin
        res.source_address = (frame_len >= 16'd30) ?
          {16'd0, hdr.fix[26], hdr.fix[27], hdr.fix[28], hdr.fix[29]} : 48'd0;
        res.dest_address   = (frame_len >= 16'd34) ?
          {16'd0, hdr.fix[30], hdr.fix[31], hdr.fix[32], hdr.fix[33]} : 48'd0;
        if (ihl < efc_pkg::IPV4_MIN_HDR) begin
          res.frame_class = efc_pkg::CLS_IPV4_BAD;
          res.code_a      = {10'd0, ihl};
        end else if (proto == efc_pkg::IP_PROTO_ICMP) begin
          res.frame_class = efc_pkg::CLS_ICMP;
          res.code_a      = (frame_len >= l4w + 16'd1) ? {8'd0, hdr.l4[0]} : 16'd0;
          res.value_a     = {16'd0,
            ((frame_len >= l4w + 16'd6) ? {hdr.l4[4], hdr.l4[5]} : 16'd0),
            ((frame_len >= l4w + 16'd8) ? {hdr.l4[6], hdr.l4[7]} : 16'd0)};
        end else if (proto == efc_pkg::IP_PROTO_TCP) begin
          res.frame_class    = efc_pkg::CLS_TCP;
          res.source_port    = sp;
          res.dest_port      = dp;
          res.source_service = ss;
          res.dest_service   = ds;
          res.code_a         = (frame_len >= l4w + 16'd14) ?
                               {8'd0, hdr.l4[13] & efc_pkg::TCP_FLAG_MASK} : 16'd0;
          res.value_a        = (frame_len >= l4w + 16'd8) ?
            {16'd0, hdr.l4[4], hdr.l4[5], hdr.l4[6], hdr.l4[7]} : 48'd0;
        end else if (proto == efc_pkg::IP_PROTO_UDP) begin
          res.frame_class    = efc_pkg::CLS_UDP;
          res.source_port    = sp;
          res.dest_port      = dp;
          res.source_service = ss;
          res.dest_service   = ds;
          res.code_a         = {11'd0, (ds != efc_pkg::SVC_NONE) ? ds : ss};
          res.value_a        = (ulen >= efc_pkg::UDP_HDR_BYTES) ?
                               {32'd0, ulen - efc_pkg::UDP_HDR_BYTES} : 48'd0;
        end else begin
          res.frame_class = efc_pkg::CLS_IPV4_OTHER;
          res.code_a      = {8'd0, proto};
        end
      end else if (typ == efc_pkg::ETYPE_ARP || typ == efc_pkg::ETYPE_RARP) begin
        res.frame_class    = (typ == efc_pkg::ETYPE_ARP) ? efc_pkg::CLS_ARP
                                                         : efc_pkg::CLS_RARP;
        res.code_a         = (frame_len >= 16'd22) ? {hdr.fix[20], hdr.fix[21]} : 16'd0;
        res.source_address = (frame_len >= 16'd32) ?
          {16'd0, hdr.fix[28], hdr.fix[29], hdr.fix[30], hdr.fix[31]} : 48'd0;
        res.dest_address   = (frame_len >= 16'd42) ?
          {16'd0, hdr.fix[38], hdr.fix[39], hdr.fix[40], hdr.fix[41]} : 48'd0;
        res.value_a        = (frame_len >= 16'd28) ?
          {hdr.fix[22], hdr.fix[23], hdr.fix[24],
           hdr.fix[25], hdr.fix[26], hdr.fix[27]} : 48'd0;
      end else if (typ == efc_pkg::ETYPE_IPV6) begin
        res.frame_class = efc_pkg::CLS_IPV6;
        res.code_a      = (frame_len >= 16'd21) ? {8'd0, hdr.fix[20]} : 16'd0;
      end else begin
        res.frame_class = efc_pkg::CLS_OTHER;
      end
    end
  end

endmodule

// ===== sv/ethernet_frame_classifier.sv =====
// ----------------------------------------------------------------------------
// ethernet_frame_classifier: Ethernet frame header classifier
// Parses an Ethernet frame arriving one byte per item and gives one summary
// item per frame.
// ----------------------------------------------------------------------------
// Usage
//   The slave channel (s_*) carries the frame one byte per item, in wire
//   order, with s_tlast high on the final byte. Frames hold at least one byte.
//   The master channel (m_*) gives one summary item per frame: the class in
//   m_tuser and the remaining fields packed in m_tdata.
//   Throughput: one byte per cycle while s_tready is high. The header bytes are captured into
//   registers as they pass, so the frame end needs no replay of the header.
//   Summary path: accepting the final byte sets the pending flag; the decode
//   then runs from the capture registers straight into the output register,
//   which loads the summary once it is empty or being emptied.
//   Stall: the summary waits in the output register while m_tready is low.
//   Bytes of the next frame keep flowing meanwhile; only when a second frame
//   has ended and its summary cannot yet enter the output register does
//   s_tready drop, until the waiting item is taken.
//   Reset (rst, synchronous, active high) clears the byte count, the pending
//   flag and m_tvalid; header registers are not cleared, as every field is
//   checked against the current frame length before it is used.
// ----------------------------------------------------------------------------
module ethernet_frame_classifier (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [7:0]   s_tdata,   // [7:0] data_byte
  input  logic         s_tlast,   // last_byte
  output logic         m_tvalid,
  input  logic         m_tready,
  // m_tdata from bit 0 up: frame_length[15:0], type_field[31:16],
  // source_address[79:32], dest_address[127:80], source_port[143:128],
  // dest_port[159:144], source_service[164:160], dest_service[169:165],
  // code_a[185:170], code_b[193:186], value_a[241:194], zeros[247:242]
  output logic [247:0] m_tdata,
  output logic [3:0]   m_tuser    // [3:0] frame_class
);

  logic          s_accept;
  logic          pend;
  logic          pend_next;
  logic          load;
  logic          m_tvalid_next;
  logic [15:0]   frame_len;
  efc_pkg::hdr_t hdr;
  efc_pkg::res_t res;

  // The capture registers must not move while a finished frame still waits
  // to be decoded, so input is held only in that case.
  assign s_tready = !pend || load;
  assign s_accept = s_tvalid && s_tready;

  efc_capture u_capture (
    .clk       (clk),
    .rst       (rst),
    .accept    (s_accept),
    .data_byte (s_tdata),
    .last_byte (s_tlast),
    .hdr       (hdr),
    .frame_len (frame_len)
  );

  efc_decode u_decode (
    .hdr       (hdr),
    .frame_len (frame_len),
    .res       (res)
  );

  // A decoded summary enters the output register when it is empty or being
  // emptied in the same cycle.
  assign load          = pend && (!m_tvalid || m_tready);
  assign pend_next     = (s_accept && s_tlast) || (pend && !load);
  assign m_tvalid_next = load || (m_tvalid && !m_tready);

  always_ff @(posedge clk) begin
    if (rst) begin
      pend     <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      pend     <= pend_next;
      m_tvalid <= m_tvalid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      m_tuser <= res.frame_class;
      m_tdata <= {6'd0,
                  res.value_a,
                  res.code_b,
                  res.code_a,
                  res.dest_service,
                  res.source_service,
                  res.dest_port,
                  res.source_port,
                  res.dest_address,
                  res.source_address,
                  res.type_field,
                  res.frame_length};
    end
  end

endmodule

// ===== sv/efc_checker.sv =====
// ----------------------------------------------------------------------------
// efc_checker: port-level checks of the frame classifier
// Watches the top-level ports for output stability, input back-pressure and
// the runt and length rules of the summary item.
// ----------------------------------------------------------------------------
module efc_checker (
  input logic         clk,
  input logic         rst,
  input logic         s_tready,
  input logic         m_tvalid,
  input logic         m_tready,
  input logic [247:0] m_tdata,
  input logic [3:0]   m_tuser
);

  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid)
    else $error("summary item withdrawn while stalled");

  a_hold_data: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser))
    else $error("summary item changed while stalled");

  a_ready_backpressure: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> m_tvalid)
    else $error("input held with no summary item waiting");

  a_runt_fields: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser == efc_pkg::CLS_RUNT |->
      m_tdata[15:0] < efc_pkg::ETH_HDR_BYTES && m_tdata[247:16] == '0)
    else $error("runt summary with a long length or a nonzero field");

  a_class_length: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser != efc_pkg::CLS_RUNT |->
      m_tdata[15:0] >= efc_pkg::ETH_HDR_BYTES)
    else $error("classified frame shorter than an Ethernet header");

endmodule

bind ethernet_frame_classifier efc_checker u_efc_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);
